[design/mlfq_job_scheduler_core_assert.svh]
// ----------------------------------------------------------------------------
// mlfq assertion macros
// shared concurrent assertion forms for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef MLFQ_JOB_SCHEDULER_CORE_ASSERT_SVH
`define MLFQ_JOB_SCHEDULER_CORE_ASSERT_SVH

// condition that holds at every edge out of reset
`define MLFQ_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define MLFQ_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define MLFQ_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg
// types and constants of the three level feedback queue scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int NLEVELS         = 3;
  localparam int AGE_BITS        = 4;

  localparam logic [3:0] QUANTUM1_RST = 4'd1;
  localparam logic [3:0] QUANTUM2_RST = 4'd2;
  localparam logic [3:0] QUANTUM3_RST = 4'd5;
  localparam logic [3:0] AGING_RST    = 4'd10;

  typedef enum logic [1:0] {
    REG_QUANTUM1 = 2'd0,
    REG_QUANTUM2 = 2'd1,
    REG_QUANTUM3 = 2'd2,
    REG_AGING    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2
  } op_t;

  typedef struct packed {
    logic [3:0] quantum1;
    logic [3:0] quantum2;
    logic [3:0] quantum3;
    logic [3:0] aging_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_OPS,
    ST_REQ,
    ST_SEL,
    ST_PUSH,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MD_AGE,
    MD_DEQ,
    MD_POP
  } mode_t;

endpackage

`default_nettype wire

[design/mlfq_job_scheduler_core.sv]
// ----------------------------------------------------------------------------
// mlfq_job_scheduler_core
// three level feedback queue scheduler, one tick per start beat
// ----------------------------------------------------------------------------
// walk: every entry aged, every entry searched by a dequeue and every entry in the picked level
//   passes through a read state and a write state, one entry at a time through the single ram port
// throughput: one tick at a time, busy stays high until the done strobe
// done lasts one cycle and cannot be stalled by the receiver
// reset: synchronous, all queues empty, no job running, registers at defaults
`default_nettype none

`include "mlfq_job_scheduler_core_assert.svh"

module mlfq_job_scheduler_core #(
  parameter int LEVEL_DEPTH = mlfq_pkg::LEVEL_DEPTH_DEF,
  parameter int ID_BITS     = mlfq_pkg::ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tick command beat
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] dequeue_id,
  input  wire logic        running_done,
  // result beat
  output logic             done,
  output logic             running_valid,
  output logic [15:0]      running_job,
  output logic [1:0]       running_level,
  output logic [15:0]      assigned_id,
  output logic             queue_full,
  output logic             dequeue_found,
  output logic             switched,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NL    = mlfq_pkg::NLEVELS;
  localparam int AB    = mlfq_pkg::AGE_BITS;
  localparam int DEPTH = NL * LEVEL_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int DW    = ID_BITS + AB;
  localparam int WB    = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [CW-1:0] FULL_CNT = CW'(LEVEL_DEPTH);

  mlfq_pkg::cfg_t cfg;

  mlfq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // queue storage: entry = {id, age}, level l occupies [l*depth, l*depth+depth)
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  mlfq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [AW-1:0] qaddr(input logic [1:0] l, input logic [CW-1:0] p);
    qaddr = AW'(int'(l) * LEVEL_DEPTH + int'(p));
  endfunction

  mlfq_pkg::state_t state, state_next;
  mlfq_pkg::mode_t  mode, mode_next;

  // scheduler state
  logic [ID_BITS-1:0] run_id, run_id_next;
  logic               run_valid, run_valid_next;
  logic [1:0]         run_level, run_level_next;
  logic [3:0]         slice_ticks, slice_ticks_next;
  logic [ID_BITS-1:0] id_counter, id_counter_next;
  logic [CW-1:0]      cnt [NL];
  logic [CW-1:0]      cnt_next [NL];

  // walk sequencer
  logic [1:0]         lv, lv_next;
  logic [CW-1:0]      rp, rp_next;
  logic [CW-1:0]      wp, wp_next;

  // per tick scratch
  logic [1:0]         op_r, op_r_next;
  logic [15:0]        deq_r, deq_r_next;
  logic               prev_valid, prev_valid_next;
  logic [ID_BITS-1:0] prev_id, prev_id_next;
  logic [ID_BITS-1:0] head_id, head_id_next;
  logic               full, full_next;
  logic               found, found_next;
  logic               sw, sw_next;
  logic [ID_BITS-1:0] assigned, assigned_next;
  logic               done_next;

  // walk data path
  logic [ID_BITS-1:0] e_id;
  logic [AB-1:0]      e_age;
  logic [AB-1:0]      age_inc;
  logic [ID_BITS-1:0] nid;
  logic [3:0]         quantum;
  logic               expired;
  logic [1:0]         drop_lv;
  logic               pick_ok;
  logic [1:0]         pick;

  assign e_id    = ram_rdata[DW-1:AB];
  assign e_age   = ram_rdata[AB-1:0];
  assign age_inc = (e_age == '1) ? e_age : e_age + AB'(1);
  assign nid     = id_counter + ID_BITS'(1);
  assign busy    = (state != mlfq_pkg::ST_IDLE);

  always_comb begin
    unique case (run_level)
      2'd2:    quantum = cfg.quantum2;
      2'd3:    quantum = cfg.quantum3;
      default: quantum = cfg.quantum1;
    endcase
  end

  assign expired = !run_valid || (slice_ticks >= ((quantum == 4'd0) ? 4'd1 : quantum));
  assign drop_lv = (run_level < 2'd3) ? run_level : 2'd2;

  // highest eligible nonempty level
  always_comb begin
    pick_ok = 1'b0;
    pick    = 2'd0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (cnt[i] != '0 && (!run_valid || (i + 1) <= int'(run_level))) begin
        pick_ok = 1'b1;
        pick    = 2'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mlfq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mlfq_pkg::ST_RD;
        end
      end
      mlfq_pkg::ST_RD: begin
        if (rp < cnt[lv]) begin
          state_next = mlfq_pkg::ST_WR;
        end else begin
          case (mode)
            mlfq_pkg::MD_AGE: if (lv == 2'd2) state_next = mlfq_pkg::ST_OPS;
            mlfq_pkg::MD_DEQ: if (lv == 2'd2 || found) state_next = mlfq_pkg::ST_SEL;
            default:          state_next = mlfq_pkg::ST_PUSH;
          endcase
        end
      end
      mlfq_pkg::ST_WR:  state_next = mlfq_pkg::ST_RD;
      mlfq_pkg::ST_OPS: begin
        priority if (op_r == mlfq_pkg::OP_ENQUEUE) begin
          state_next = (cnt[0] < FULL_CNT && run_valid) ? mlfq_pkg::ST_REQ : mlfq_pkg::ST_SEL;
        end else if (op_r == mlfq_pkg::OP_DEQUEUE) begin
          state_next = (run_valid && WB'(run_id) == WB'(deq_r)) ?
                       mlfq_pkg::ST_SEL : mlfq_pkg::ST_RD;
        end else begin
          state_next = mlfq_pkg::ST_SEL;
        end
      end
      mlfq_pkg::ST_REQ: state_next = mlfq_pkg::ST_SEL;
      mlfq_pkg::ST_SEL: begin
        state_next = (expired && pick_ok) ? mlfq_pkg::ST_RD : mlfq_pkg::ST_FIN;
      end
      mlfq_pkg::ST_PUSH: state_next = mlfq_pkg::ST_FIN;
      mlfq_pkg::ST_FIN:  state_next = mlfq_pkg::ST_IDLE;
      default:           state_next = mlfq_pkg::ST_IDLE;
    endcase
  end

  // data path and ram control
  always_comb begin
    mode_next        = mode;
    run_id_next      = run_id;
    run_valid_next   = run_valid;
    run_level_next   = run_level;
    slice_ticks_next = slice_ticks;
    id_counter_next  = id_counter;
    for (int i = 0; i < NL; i++) cnt_next[i] = cnt[i];
    lv_next          = lv;
    rp_next          = rp;
    wp_next          = wp;
    op_r_next        = op_r;
    deq_r_next       = deq_r;
    prev_valid_next  = prev_valid;
    prev_id_next     = prev_id;
    head_id_next     = head_id;
    full_next        = full;
    found_next       = found;
    sw_next          = sw;
    assigned_next    = assigned;
    done_next        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = {e_id, e_age};
    ram_raddr        = qaddr(lv, rp);

    unique case (state)
      mlfq_pkg::ST_IDLE: begin
        if (start) begin
          if (slice_ticks != 4'd15) slice_ticks_next = slice_ticks + 4'd1;
          if (running_done) run_valid_next = 1'b0;
          prev_valid_next = run_valid;
          prev_id_next    = run_id;
          op_r_next       = op;
          deq_r_next      = dequeue_id;
          full_next       = 1'b0;
          found_next      = 1'b0;
          sw_next         = 1'b0;
          assigned_next   = '0;
          mode_next       = mlfq_pkg::MD_AGE;
          lv_next         = 2'd0;
          rp_next         = '0;
          wp_next         = '0;
        end
      end

      mlfq_pkg::ST_RD: begin
        if (!(rp < cnt[lv])) begin
          // level finished: compacted length is the write pointer
          cnt_next[lv] = wp;
          lv_next      = lv + 2'd1;
          rp_next      = '0;
          wp_next      = '0;
        end
      end

      mlfq_pkg::ST_WR: begin
        rp_next = rp + CW'(1);
        case (mode)
          mlfq_pkg::MD_AGE: begin
            if (lv != 2'd0 && age_inc >= cfg.aging_limit && cnt[lv - 2'd1] < FULL_CNT) begin
              // promote to the tail of the level above
              ram_we             = 1'b1;
              ram_waddr          = qaddr(lv - 2'd1, cnt[lv - 2'd1]);
              ram_wdata          = {e_id, AB'(0)};
              cnt_next[lv - 2'd1] = cnt[lv - 2'd1] + CW'(1);
            end else begin
              ram_we    = 1'b1;
              ram_waddr = qaddr(lv, wp);
              ram_wdata = {e_id, age_inc};
              wp_next   = wp + CW'(1);
            end
          end
          mlfq_pkg::MD_DEQ: begin
            if (!found && WB'(e_id) == WB'(deq_r)) begin
              found_next = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = qaddr(lv, wp);
              wp_next   = wp + CW'(1);
            end
          end
          default: begin
            if (rp == '0) begin
              head_id_next = e_id;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = qaddr(lv, wp);
              wp_next   = wp + CW'(1);
            end
          end
        endcase
      end

      mlfq_pkg::ST_OPS: begin
        priority if (op_r == mlfq_pkg::OP_ENQUEUE) begin
          if (cnt[0] < FULL_CNT) begin
            ram_we          = 1'b1;
            ram_waddr       = qaddr(2'd0, cnt[0]);
            ram_wdata       = {nid, AB'(0)};
            cnt_next[0]     = cnt[0] + CW'(1);
            id_counter_next = nid;
            assigned_next   = nid;
          end else begin
            full_next = 1'b1;
          end
        end else if (op_r == mlfq_pkg::OP_DEQUEUE) begin
          if (run_valid && WB'(run_id) == WB'(deq_r)) begin
            run_valid_next = 1'b0;
            found_next     = 1'b1;
          end else begin
            mode_next = mlfq_pkg::MD_DEQ;
            lv_next   = 2'd0;
            rp_next   = '0;
            wp_next   = '0;
          end
        end else begin
          found_next = found;
        end
      end

      mlfq_pkg::ST_REQ: begin
        // preempted job back to the tail of its own level
        if (cnt[run_level - 2'd1] < FULL_CNT) begin
          ram_we                   = 1'b1;
          ram_waddr                = qaddr(run_level - 2'd1, cnt[run_level - 2'd1]);
          ram_wdata                = {run_id, AB'(0)};
          cnt_next[run_level - 2'd1] = cnt[run_level - 2'd1] + CW'(1);
        end else begin
          full_next = 1'b1;
        end
        run_valid_next = 1'b0;
      end

      mlfq_pkg::ST_SEL: begin
        if (expired) begin
          slice_ticks_next = 4'd0;
          if (pick_ok) begin
            mode_next = mlfq_pkg::MD_POP;
            lv_next   = pick;
            rp_next   = '0;
            wp_next   = '0;
          end else if (run_valid && run_level < 2'd3) begin
            run_level_next = run_level + 2'd1;
          end
        end
      end

      mlfq_pkg::ST_PUSH: begin
        // lv has stepped one past the picked level, so it is that level counted from one
        if (run_valid) begin
          if (cnt[drop_lv] < FULL_CNT) begin
            ram_we            = 1'b1;
            ram_waddr         = qaddr(drop_lv, cnt[drop_lv]);
            ram_wdata         = {run_id, AB'(0)};
            cnt_next[drop_lv] = cnt[drop_lv] + CW'(1);
          end else begin
            full_next = 1'b1;
          end
        end
        run_id_next    = head_id;
        run_level_next = lv;
        run_valid_next = 1'b1;
        sw_next        = !prev_valid || prev_id != head_id;
      end

      mlfq_pkg::ST_FIN: begin
        done_next = 1'b1;
      end

      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mlfq_pkg::ST_IDLE;
      mode        <= mlfq_pkg::MD_AGE;
      run_id      <= '0;
      run_valid   <= 1'b0;
      run_level   <= 2'd1;
      slice_ticks <= 4'd0;
      id_counter  <= '0;
      for (int i = 0; i < NL; i++) cnt[i] <= '0;
      lv          <= 2'd0;
      rp          <= '0;
      wp          <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      mode        <= mode_next;
      run_id      <= run_id_next;
      run_valid   <= run_valid_next;
      run_level   <= run_level_next;
      slice_ticks <= slice_ticks_next;
      id_counter  <= id_counter_next;
      for (int i = 0; i < NL; i++) cnt[i] <= cnt_next[i];
      lv          <= lv_next;
      rp          <= rp_next;
      wp          <= wp_next;
      done        <= done_next;
    end
  end

  // tick scratch and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    deq_r      <= deq_r_next;
    prev_valid <= prev_valid_next;
    prev_id    <= prev_id_next;
    head_id    <= head_id_next;
    full       <= full_next;
    found      <= found_next;
    sw         <= sw_next;
    assigned   <= assigned_next;
    if (state == mlfq_pkg::ST_FIN) begin
      running_valid <= run_valid;
      running_job   <= run_valid ? 16'(run_id) : 16'd0;
      running_level <= run_valid ? run_level : 2'd0;
      assigned_id   <= 16'(assigned);
      queue_full    <= full;
      dequeue_found <= found;
      switched      <= sw;
    end
  end

  `MLFQ_NEXT(a_accept_busy, start && !busy, busy, "tick accepted but block not busy")
  `MLFQ_IMPLY(a_done_from_fin, done, $past(state) == mlfq_pkg::ST_FIN, "stray result strobe")
  `MLFQ_CHECK(a_cnt_bound, cnt[0] <= FULL_CNT && cnt[1] <= FULL_CNT && cnt[2] <= FULL_CNT, "level count overflow")
  `MLFQ_IMPLY(a_idle_result, done && !running_valid, running_job == 16'd0 && running_level == 2'd0, "idle result not zero")
  `MLFQ_CHECK(a_level_range, run_level != 2'd0, "run level out of range")

endmodule

`default_nettype wire

[design/mlfq_ram.sv]
// ----------------------------------------------------------------------------
// mlfq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/mlfq_cfg.sv]
// ----------------------------------------------------------------------------
// mlfq_cfg
// apb register file holding slice lengths and the aging limit
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output mlfq_pkg::cfg_t      cfg
);

  mlfq_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = mlfq_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quantum1    <= mlfq_pkg::QUANTUM1_RST;
      cfg.quantum2    <= mlfq_pkg::QUANTUM2_RST;
      cfg.quantum3    <= mlfq_pkg::QUANTUM3_RST;
      cfg.aging_limit <= mlfq_pkg::AGING_RST;
    end else if (wr) begin
      unique case (idx)
        mlfq_pkg::REG_QUANTUM1: cfg.quantum1    <= pwdata[3:0];
        mlfq_pkg::REG_QUANTUM2: cfg.quantum2    <= pwdata[3:0];
        mlfq_pkg::REG_QUANTUM3: cfg.quantum3    <= pwdata[3:0];
        mlfq_pkg::REG_AGING:    cfg.aging_limit <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mlfq_pkg::REG_QUANTUM1: prdata = {28'd0, cfg.quantum1};
      mlfq_pkg::REG_QUANTUM2: prdata = {28'd0, cfg.quantum2};
      mlfq_pkg::REG_QUANTUM3: prdata = {28'd0, cfg.quantum3};
      mlfq_pkg::REG_AGING:    prdata = {28'd0, cfg.aging_limit};
    endcase
  end

endmodule

`default_nettype wire
